[src/ctlf_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and request/response types for the closed tour length block.
// No dependencies; imported by every module under src.
package ctlf_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 8;
    localparam int MAX_CITIES = 256;
    localparam int LEN_BITS   = 29;
    localparam int FIT_BITS   = 32;
    localparam int FIT_FRAC   = 16;
    localparam int SCALE_BITS = 16;
    localparam int ADDR_BITS  = 3;
    localparam int DATA_BITS  = 32;

    localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(1000);
    localparam logic                  REG_SCALE   = 1'b0;

    // sum of two squares and its digit-serial square root
    localparam int SUM_BITS  = 2 * COORD_BITS + 1;
    localparam int SQ_PAIRS  = (SUM_BITS + 1) / 2;
    localparam int V_BITS    = 2 * SQ_PAIRS;
    localparam int ITERS     = SQ_PAIRS + FRAC_BITS;
    localparam int ROOT_BITS = ITERS;
    localparam int REM_BITS  = ROOT_BITS + 2;
    localparam int ICNT_BITS = $clog2(ITERS);

    // bit-serial divider
    localparam int DIVD_BITS = SCALE_BITS + FIT_FRAC + FRAC_BITS;
    localparam int DCNT_BITS = $clog2(DIVD_BITS);

    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
    localparam logic [FIT_BITS-1:0] FIT_MAX = '1;

    typedef struct packed {
        logic                  start;
        logic [COORD_BITS-1:0] ax;
        logic [COORD_BITS-1:0] ay;
        logic [COORD_BITS-1:0] bx;
        logic [COORD_BITS-1:0] by;
    } edge_req_t;

    typedef struct packed {
        logic                 done;
        logic [ROOT_BITS-1:0] edge_len;
    } edge_rsp_t;

    typedef struct packed {
        logic                  start;
        logic [SCALE_BITS-1:0] scale;
        logic [LEN_BITS-1:0]   length;
    } div_req_t;

endpackage

[src/ctlf_edge.sv]
`timescale 1ns / 1ps
// Edge length unit: squares the coordinate deltas on one shared multiplier,
// then takes the root two bits per cycle. Depends on ctlf_pkg.
module ctlf_edge
    import ctlf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  edge_req_t req,
    output edge_rsp_t rsp
);

    typedef enum logic [1:0] {
        E_IDLE,
        E_SQX,
        E_SQY,
        E_ROOT
    } edge_state_t;

    edge_state_t            state_reg;
    logic [COORD_BITS-1:0]  dx_reg;
    logic [COORD_BITS-1:0]  dy_reg;
    logic [V_BITS-1:0]      v_reg;
    logic [REM_BITS-1:0]    rem_reg;
    logic [ROOT_BITS-1:0]   root_reg;
    logic [ICNT_BITS-1:0]   cnt_reg;
    logic                   done_reg;

    logic [COORD_BITS-1:0]   dx_next;
    logic [COORD_BITS-1:0]   dy_next;
    logic [COORD_BITS-1:0]   mul_in;
    logic [2*COORD_BITS-1:0] prod;
    logic [REM_BITS+1:0]     rem_shift;
    logic [REM_BITS+1:0]     trial;
    logic                    take;

    assign dx_next   = (req.ax > req.bx) ? req.ax - req.bx : req.bx - req.ax;
    assign dy_next   = (req.ay > req.by) ? req.ay - req.by : req.by - req.ay;
    assign mul_in    = (state_reg == E_SQX) ? dx_reg : dy_reg;
    assign prod      = (2*COORD_BITS)'(mul_in) * (2*COORD_BITS)'(mul_in);
    assign rem_shift = {rem_reg, v_reg[V_BITS-1 -: 2]};
    assign trial     = (REM_BITS+2)'({root_reg, 2'b01});
    assign take      = (rem_shift >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            dx_reg    <= '0;
            dy_reg    <= '0;
            v_reg     <= '0;
            rem_reg   <= '0;
            root_reg  <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                E_IDLE:
                begin
                    if (req.start)
                    begin
                        dx_reg    <= dx_next;
                        dy_reg    <= dy_next;
                        state_reg <= E_SQX;
                    end
                end
                E_SQX:
                begin
                    v_reg     <= V_BITS'(prod);
                    state_reg <= E_SQY;
                end
                E_SQY:
                begin
                    v_reg     <= v_reg + V_BITS'(prod);
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= ICNT_BITS'(ITERS - 1);
                    state_reg <= E_ROOT;
                end
                E_ROOT:
                begin
                    // advance one root digit; fraction pairs shift in as zeros
                    v_reg <= {v_reg[V_BITS-3:0], 2'b00};
                    if (take)
                    begin
                        rem_reg  <= REM_BITS'(rem_shift - trial);
                        root_reg <= {root_reg[ROOT_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= REM_BITS'(rem_shift);
                        root_reg <= {root_reg[ROOT_BITS-2:0], 1'b0};
                    end
                    if (cnt_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= E_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.edge_len = root_reg;

endmodule

[src/ctlf_div.sv]
`timescale 1ns / 1ps
// Bit-serial restoring divider for the fitness quotient, with the result
// output register. Depends on ctlf_pkg.
module ctlf_div
    import ctlf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  div_req_t            req,
    output logic                req_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [LEN_BITS-1:0] tour_length,
    output logic [FIT_BITS-1:0] tour_fitness
);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_HOLD
    } div_state_t;

    div_state_t              state_reg;
    logic [LEN_BITS-1:0]     divisor_reg;
    logic [LEN_BITS-1:0]     rem_reg;
    logic [DIVD_BITS-1:0]    quo_reg;
    logic [DCNT_BITS-1:0]    cnt_reg;
    logic                    out_valid_reg;
    logic [LEN_BITS-1:0]     length_reg;
    logic [FIT_BITS-1:0]     fitness_reg;

    logic [LEN_BITS:0]       rem_shift;
    logic                    qbit;
    logic                    saturate;
    logic [FIT_BITS-1:0]     fitness_next;
    logic                    load_out;

    assign rem_shift    = {rem_reg, quo_reg[DIVD_BITS-1]};
    assign qbit         = (rem_shift >= {1'b0, divisor_reg});
    assign saturate     = (divisor_reg == '0) || (|quo_reg[DIVD_BITS-1:FIT_BITS]);
    assign fitness_next = saturate ? FIT_MAX : quo_reg[FIT_BITS-1:0];
    assign load_out     = (state_reg == D_HOLD) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= D_IDLE;
            divisor_reg   <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            length_reg    <= '0;
            fitness_reg   <= '0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                D_IDLE:
                begin
                    if (req.start)
                    begin
                        divisor_reg <= req.length;
                        rem_reg     <= '0;
                        quo_reg     <= DIVD_BITS'(req.scale) << (FIT_FRAC + FRAC_BITS);
                        cnt_reg     <= DCNT_BITS'(DIVD_BITS - 1);
                        state_reg   <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    rem_reg <= qbit ? LEN_BITS'(rem_shift - {1'b0, divisor_reg})
                                    : LEN_BITS'(rem_shift);
                    quo_reg <= {quo_reg[DIVD_BITS-2:0], qbit};
                    if (cnt_reg == '0)
                    begin
                        state_reg <= D_HOLD;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                D_HOLD:
                begin
                    // hold the quotient until the output register is free
                    if (load_out)
                    begin
                        length_reg  <= divisor_reg;
                        fitness_reg <= fitness_next;
                        state_reg   <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign req_ready    = (state_reg == D_IDLE);
    assign out_valid    = out_valid_reg;
    assign tour_length  = length_reg;
    assign tour_fitness = fitness_reg;

endmodule

[src/closed_tour_length_fitness.sv]
`timescale 1ns / 1ps
// Top level of the closed tour length and fitness block: tour state, APB
// register and sequencing. Depends on ctlf_pkg, ctlf_edge and ctlf_div.
//
//  port group  direction  handshake            payload
//  in          request    in_valid/in_ready    city_x, city_y, last_city
//  out         result     out_valid/out_ready  tour_length, tour_fitness
//  apb         config     psel/penable/pready  paddr, pwrite, pwdata, prdata
//
//  In the edge unit each edge runs launch, two squaring steps on one multiplier
//  (E_SQX, E_SQY), ITERS = 21 root digits in E_ROOT, then done. The first city
//  of a tour launches no edge; a last city also launches the closing edge.
//  The divider runs on while the next tour is accepted.
//  Reset clears the tour, sets fitness_scale to 1000 and needs no sweep.
//  A stalled result stays in the output register; a second one waits in the divider.
module closed_tour_length_fitness
    import ctlf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] city_x,
    input  logic [COORD_BITS-1:0] city_y,
    input  logic                  last_city,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [LEN_BITS-1:0]   tour_length,
    output logic [FIT_BITS-1:0]   tour_fitness,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [DATA_BITS-1:0]  pwdata,
    output logic [DATA_BITS-1:0]  prdata,
    output logic                  pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE1,
        ST_CLOSE,
        ST_EDGE2,
        ST_HAND
    } top_state_t;

    top_state_t             state_reg;
    logic [SCALE_BITS-1:0]  scale_reg;
    logic [COORD_BITS-1:0]  start_x_reg;
    logic [COORD_BITS-1:0]  start_y_reg;
    logic [COORD_BITS-1:0]  prior_x_reg;
    logic [COORD_BITS-1:0]  prior_y_reg;
    logic [COORD_BITS-1:0]  cur_x_reg;
    logic [COORD_BITS-1:0]  cur_y_reg;
    logic [LEN_BITS-1:0]    length_reg;
    logic                   started_reg;
    logic                   last_reg;

    logic                   accept;
    logic                   closing;
    logic                   div_ready;
    logic [LEN_BITS:0]      length_sum;
    logic [LEN_BITS-1:0]    length_next;
    edge_req_t              edge_req;
    edge_rsp_t              edge_rsp;
    div_req_t               div_req;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign closing  = (state_reg == ST_CLOSE);

    assign edge_req.start = (accept && started_reg) || closing;
    assign edge_req.ax    = closing ? cur_x_reg   : prior_x_reg;
    assign edge_req.ay    = closing ? cur_y_reg   : prior_y_reg;
    assign edge_req.bx    = closing ? start_x_reg : city_x;
    assign edge_req.by    = closing ? start_y_reg : city_y;

    assign length_sum  = (LEN_BITS+1)'(length_reg) + (LEN_BITS+1)'(edge_rsp.edge_len);
    assign length_next = length_sum[LEN_BITS] ? LEN_MAX : length_sum[LEN_BITS-1:0];

    assign div_req.start  = (state_reg == ST_HAND) && div_ready;
    assign div_req.scale  = scale_reg;
    assign div_req.length = length_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SCALE) ? DATA_BITS'(scale_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            scale_reg   <= SCALE_RESET;
            start_x_reg <= '0;
            start_y_reg <= '0;
            prior_x_reg <= '0;
            prior_y_reg <= '0;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            length_reg  <= '0;
            started_reg <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && (paddr[2] == REG_SCALE))
            begin
                scale_reg <= pwdata[SCALE_BITS-1:0];
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        prior_x_reg <= city_x;
                        prior_y_reg <= city_y;
                        cur_x_reg   <= city_x;
                        cur_y_reg   <= city_y;
                        last_reg    <= last_city;
                        if (!started_reg)
                        begin
                            start_x_reg <= city_x;
                            start_y_reg <= city_y;
                            length_reg  <= '0;
                            started_reg <= 1'b1;
                            if (last_city)
                            begin
                                state_reg <= ST_CLOSE;
                            end
                        end
                        else
                        begin
                            state_reg <= ST_EDGE1;
                        end
                    end
                end
                ST_EDGE1:
                begin
                    if (edge_rsp.done)
                    begin
                        length_reg <= length_next;
                        state_reg  <= last_reg ? ST_CLOSE : ST_IDLE;
                    end
                end
                ST_CLOSE:
                begin
                    state_reg <= ST_EDGE2;
                end
                ST_EDGE2:
                begin
                    if (edge_rsp.done)
                    begin
                        length_reg <= length_next;
                        state_reg  <= ST_HAND;
                    end
                end
                ST_HAND:
                begin
                    // hand the length to the divider once it is free
                    if (div_ready)
                    begin
                        started_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    ctlf_edge u_edge (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (edge_req),
        .rsp   (edge_rsp)
    );

    ctlf_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (div_req),
        .req_ready    (div_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .tour_length  (tour_length),
        .tour_fitness (tour_fitness)
    );

    a_done_in_edge: assert property (@(posedge clk) disable iff (!rst_n)
        edge_rsp.done |-> (state_reg == ST_EDGE1 || state_reg == ST_EDGE2))
        else $error("edge result outside an edge wait");

    a_edge_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        edge_req.start |=> !edge_rsp.done)
        else $error("edge result one cycle after launch");

    a_first_city_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !started_reg) |=> (length_reg == '0 && started_reg))
        else $error("first city did not clear the length");

    a_tour_end_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(started_reg) |-> $past(div_req.start))
        else $error("tour closed without a divider request");

endmodule
